// File: hw/rtl/rmp_pkg.sv
// Shared types and constants for the RESP multibulk request parser.
// No dependencies; used by rmp_step and resp_multibulk_request_parser_top.
`default_nettype none

package rmp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CSTART = 4'd1,
        PH_CDIG   = 4'd2,
        PH_CBAD   = 4'd3,
        PH_CLF    = 4'd4,
        PH_DOLLAR = 4'd5,
        PH_DBAD   = 4'd6,
        PH_BSTART = 4'd7,
        PH_BDIG   = 4'd8,
        PH_BBAD   = 4'd9,
        PH_BLF    = 4'd10,
        PH_DATA   = 4'd11,
        PH_SKIP1  = 4'd12,
        PH_SKIP2  = 4'd13,
        PH_ERR    = 4'd14
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_COUNT = 3'd1,
        ERR_NO_DOLLAR = 3'd2,
        ERR_BAD_BULK  = 3'd3,
        ERR_LINE_LONG = 3'd4,
        ERR_INLINE    = 3'd5
    } err_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_ARG_COUNT   = 2'd0;
    localparam logic [1:0] REG_MAX_BULK_LENGTH = 2'd1;
    localparam logic [1:0] REG_MAX_HEADER_LINE = 2'd2;

    localparam logic [20:0] MAX_ARG_COUNT_RST   = 21'd1048576;
    localparam logic [29:0] MAX_BULK_LENGTH_RST = 30'd536870912;
    localparam logic [16:0] MAX_HEADER_LINE_RST = 17'd65536;

    localparam logic [33:0] DIGIT_MAX = 34'h3_FFFF_FFFF;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    typedef struct packed {
        phase_t      phase;
        logic        negative_sign;
        logic [33:0] digit_value;
        logic [16:0] line_length;
        logic [20:0] args_left;
        logic [29:0] bytes_left;
        logic [19:0] current_arg;
        err_t        sticky_error;
    } state_t;

    typedef struct packed {
        logic       valid;
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       arg_end;
        logic       command_end;
        err_t       error_code;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/rmp_step.sv
// Per-byte parser step: next parser state and the optional result beat.
// Depends on rmp_pkg for the state, result and error types.
`default_nettype none

module rmp_step (
    input  wire rmp_pkg::state_t  st,
    input  wire logic [7:0]       in_byte,
    input  wire logic [20:0]      max_arg_count,
    input  wire logic [29:0]      max_bulk_length,
    input  wire logic [16:0]      max_header_line,
    output rmp_pkg::state_t       st_next,
    output rmp_pkg::result_t      res
);

    logic        is_cr;
    logic        is_digit;
    logic [3:0]  digit;
    logic [17:0] line_inc;
    logic        line_over;
    logic        first_over;
    logic        num_start;
    logic        num_dig;
    logic        num_bad;
    logic        go_dig;
    logic        go_bad;
    logic        set_neg;
    logic [33:0] digit_acc;
    logic [37:0] acc_wide;
    logic [20:0] args_dec;
    logic [29:0] bytes_dec;
    rmp_pkg::err_t raise;

    assign is_cr      = (in_byte == rmp_pkg::CHAR_CR);
    assign is_digit   = (in_byte >= rmp_pkg::CHAR_ZERO) && (in_byte <= rmp_pkg::CHAR_NINE);
    assign digit      = 4'(in_byte - rmp_pkg::CHAR_ZERO);
    assign line_inc   = {1'b0, st.line_length} + 18'd1;
    assign line_over  = line_inc > {1'b0, max_header_line};
    assign first_over = (max_header_line == 17'd0);
    assign args_dec   = st.args_left - 21'd1;
    assign bytes_dec  = st.bytes_left - 30'd1;

    assign num_start = (st.phase == rmp_pkg::PH_CSTART) || (st.phase == rmp_pkg::PH_BSTART);
    assign num_dig   = (st.phase == rmp_pkg::PH_CDIG) || (st.phase == rmp_pkg::PH_BDIG);
    assign num_bad   = (st.phase == rmp_pkg::PH_CBAD) || (st.phase == rmp_pkg::PH_BBAD);

    // Decimal accumulate is v*10 + d as two shifted adds, saturating at the top.
    assign acc_wide = {1'b0, st.digit_value, 3'b000} + {3'b000, st.digit_value, 1'b0}
                    + {34'd0, digit};
    assign digit_acc = (acc_wide > {4'd0, rmp_pkg::DIGIT_MAX}) ? rmp_pkg::DIGIT_MAX
                                                               : acc_wide[33:0];

    // A leading zero may not be followed by more digits, and "-0" is bad.
    always_comb
    begin
        go_dig  = 1'b0;
        go_bad  = 1'b0;
        set_neg = 1'b0;
        if (num_bad) begin
            go_bad = 1'b1;
        end
        else if (is_digit) begin
            if (num_start) begin
                if (digit == 4'd0 && st.negative_sign) go_bad = 1'b1;
                else                                   go_dig = 1'b1;
            end
            else if (st.digit_value == 34'd0) begin
                go_bad = 1'b1;
            end
            else begin
                go_dig = 1'b1;
            end
        end
        else if (in_byte == rmp_pkg::CHAR_MINUS && num_start && !st.negative_sign) begin
            set_neg = 1'b1;
        end
        else begin
            go_bad = 1'b1;
        end
    end

    // Error raised by this byte, if any.
    always_comb
    begin
        raise = rmp_pkg::ERR_NONE;
        case (st.phase)
            rmp_pkg::PH_IDLE:
            begin
                if (in_byte != rmp_pkg::CHAR_STAR) raise = rmp_pkg::ERR_INLINE;
                else if (first_over)               raise = rmp_pkg::ERR_LINE_LONG;
            end
            rmp_pkg::PH_CSTART, rmp_pkg::PH_CDIG, rmp_pkg::PH_CBAD:
            begin
                if (is_cr) begin
                    if (st.phase != rmp_pkg::PH_CDIG)
                        raise = rmp_pkg::ERR_BAD_COUNT;
                    else if (!st.negative_sign && st.digit_value != 34'd0
                             && st.digit_value > {13'd0, max_arg_count})
                        raise = rmp_pkg::ERR_BAD_COUNT;
                end
                else if (line_over) begin
                    raise = rmp_pkg::ERR_LINE_LONG;
                end
            end
            rmp_pkg::PH_DOLLAR:
            begin
                if (is_cr)           raise = rmp_pkg::ERR_NO_DOLLAR;
                else if (first_over) raise = rmp_pkg::ERR_LINE_LONG;
            end
            rmp_pkg::PH_DBAD:
            begin
                if (is_cr)          raise = rmp_pkg::ERR_NO_DOLLAR;
                else if (line_over) raise = rmp_pkg::ERR_LINE_LONG;
            end
            rmp_pkg::PH_BSTART, rmp_pkg::PH_BDIG, rmp_pkg::PH_BBAD:
            begin
                if (is_cr) begin
                    if (st.phase != rmp_pkg::PH_BDIG || st.negative_sign
                        || st.digit_value > {4'd0, max_bulk_length})
                        raise = rmp_pkg::ERR_BAD_BULK;
                end
                else if (line_over) begin
                    raise = rmp_pkg::ERR_LINE_LONG;
                end
            end
            default:
            begin
                raise = rmp_pkg::ERR_NONE;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        st_next = st;
        if (raise != rmp_pkg::ERR_NONE) begin
            st_next.phase        = rmp_pkg::PH_ERR;
            st_next.sticky_error = raise;
        end
        else begin
            case (st.phase)
                rmp_pkg::PH_IDLE, rmp_pkg::PH_DOLLAR:
                begin
                    st_next.line_length   = 17'd1;
                    st_next.negative_sign = 1'b0;
                    st_next.digit_value   = 34'd0;
                    if (st.phase == rmp_pkg::PH_IDLE)
                        st_next.phase = rmp_pkg::PH_CSTART;
                    else if (in_byte == rmp_pkg::CHAR_DOLLAR)
                        st_next.phase = rmp_pkg::PH_BSTART;
                    else
                        st_next.phase = rmp_pkg::PH_DBAD;
                end
                rmp_pkg::PH_CSTART, rmp_pkg::PH_CDIG, rmp_pkg::PH_CBAD,
                rmp_pkg::PH_BSTART, rmp_pkg::PH_BDIG, rmp_pkg::PH_BBAD:
                begin
                    if (is_cr) begin
                        if (num_dig && st.phase == rmp_pkg::PH_CDIG) begin
                            st_next.phase = rmp_pkg::PH_CLF;
                            if (st.negative_sign || st.digit_value == 34'd0)
                                st_next.args_left = 21'd0;
                            else
                                st_next.args_left = st.digit_value[20:0];
                        end
                        else begin
                            st_next.phase      = rmp_pkg::PH_BLF;
                            st_next.bytes_left = st.digit_value[29:0];
                        end
                    end
                    else begin
                        st_next.line_length = line_inc[16:0];
                        if (set_neg) st_next.negative_sign = 1'b1;
                        if (go_dig) begin
                            st_next.digit_value = num_start ? {30'd0, digit} : digit_acc;
                            st_next.phase = (st.phase <= rmp_pkg::PH_CBAD) ? rmp_pkg::PH_CDIG
                                                                           : rmp_pkg::PH_BDIG;
                        end
                        else if (go_bad) begin
                            st_next.phase = (st.phase <= rmp_pkg::PH_CBAD) ? rmp_pkg::PH_CBAD
                                                                           : rmp_pkg::PH_BBAD;
                        end
                    end
                end
                rmp_pkg::PH_CLF:
                begin
                    st_next.current_arg = 20'd0;
                    st_next.phase = (st.args_left != 21'd0) ? rmp_pkg::PH_DOLLAR
                                                            : rmp_pkg::PH_IDLE;
                end
                rmp_pkg::PH_DBAD:
                begin
                    st_next.line_length = line_inc[16:0];
                end
                rmp_pkg::PH_BLF:
                begin
                    if (st.bytes_left == 30'd0) begin
                        st_next.args_left = args_dec;
                        st_next.phase     = rmp_pkg::PH_SKIP1;
                    end
                    else begin
                        st_next.phase = rmp_pkg::PH_DATA;
                    end
                end
                rmp_pkg::PH_DATA:
                begin
                    st_next.bytes_left = bytes_dec;
                    if (bytes_dec == 30'd0) begin
                        st_next.args_left = args_dec;
                        st_next.phase     = rmp_pkg::PH_SKIP1;
                    end
                end
                rmp_pkg::PH_SKIP1:
                begin
                    st_next.phase = rmp_pkg::PH_SKIP2;
                end
                rmp_pkg::PH_SKIP2:
                begin
                    if (st.args_left == 21'd0) begin
                        st_next.current_arg = 20'd0;
                        st_next.phase       = rmp_pkg::PH_IDLE;
                    end
                    else begin
                        st_next.current_arg = st.current_arg + 20'd1;
                        st_next.phase       = rmp_pkg::PH_DOLLAR;
                    end
                end
                default:
                begin
                    st_next.phase = st.phase;
                end
            endcase
        end
    end

    // Result beat.
    always_comb
    begin
        res = '{valid: 1'b0, byte_valid: 1'b0, out_byte: 8'd0, arg_end: 1'b0,
                command_end: 1'b0, error_code: st.sticky_error};
        if (raise != rmp_pkg::ERR_NONE) begin
            res.valid      = 1'b1;
            res.error_code = raise;
        end
        else begin
            case (st.phase)
                rmp_pkg::PH_BLF:
                begin
                    if (st.bytes_left == 30'd0) begin
                        res.valid       = 1'b1;
                        res.arg_end     = 1'b1;
                        res.command_end = (args_dec == 21'd0);
                    end
                end
                rmp_pkg::PH_DATA:
                begin
                    res.valid      = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = in_byte;
                    if (bytes_dec == 30'd0) begin
                        res.arg_end     = 1'b1;
                        res.command_end = (args_dec == 21'd0);
                    end
                end
                default:
                begin
                    res.valid = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/resp_multibulk_request_parser_top.sv
// Top level of the RESP multibulk request parser: handshakes, config and state registers.
// Depends on rmp_pkg and rmp_step.
//
//   Channel   Handshake              Payload
//   ------    ---------------------  --------------------------------------------------
//   input     in_valid / in_ready    in_byte
//   output    out_valid / out_ready  byte_valid, out_byte, arg_index, arg_end,
//                                    command_end, error_code
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The parser state register and the step logic handle one byte per clock while in_ready
// is high, and a result is written into the output register in the same edge that accepts
// the byte.
// in_ready is low only while the output register is full and not being drained,
// so a stalled consumer stalls the input after one pending result beat.
// Reset is asynchronous and active low; it returns the parser to waiting for a
// request start, clears the sticky error and loads the register defaults.
// The configuration port is always ready and takes one write per cycle.
`default_nettype none

module resp_multibulk_request_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             byte_valid,
    output logic [7:0]       out_byte,
    output logic [19:0]      arg_index,
    output logic             arg_end,
    output logic             command_end,
    output logic [2:0]       error_code,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [29:0] cfg_data
);

    rmp_pkg::state_t  st_reg;
    rmp_pkg::state_t  st_next;
    rmp_pkg::result_t res;

    logic [20:0] max_arg_count_reg;
    logic [29:0] max_bulk_length_reg;
    logic [16:0] max_header_line_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        byte_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [19:0] arg_index_reg;
    logic        arg_end_reg;
    logic        command_end_reg;
    logic [2:0]  error_code_reg;

    logic in_accept;
    logic load_result;

    rmp_step u_step (
        .st              (st_reg),
        .in_byte         (in_byte),
        .max_arg_count   (max_arg_count_reg),
        .max_bulk_length (max_bulk_length_reg),
        .max_header_line (max_header_line_reg),
        .st_next         (st_next),
        .res             (res)
    );

    assign in_ready    = !out_valid_reg || out_ready;
    assign in_accept   = in_valid && in_ready;
    assign load_result = in_accept && res.valid;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        if (load_result)    out_valid_next = 1'b1;
        else if (out_ready) out_valid_next = 1'b0;
        else                out_valid_next = out_valid_reg;
    end

    // Parser state advances on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= '{phase: rmp_pkg::PH_IDLE, negative_sign: 1'b0, digit_value: 34'd0,
                        line_length: 17'd0, args_left: 21'd0, bytes_left: 30'd0,
                        current_arg: 20'd0, sticky_error: rmp_pkg::ERR_NONE};
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_accept) st_reg <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register; it only loads when a new beat is produced.
    always_ff @(posedge clk)
    begin
        if (load_result) begin
            byte_valid_reg  <= res.byte_valid;
            out_byte_reg    <= res.out_byte;
            arg_index_reg   <= st_reg.current_arg;
            arg_end_reg     <= res.arg_end;
            command_end_reg <= res.command_end;
            error_code_reg  <= res.error_code;
        end
    end

    // Configuration registers. A write to an unused index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_arg_count_reg   <= rmp_pkg::MAX_ARG_COUNT_RST;
            max_bulk_length_reg <= rmp_pkg::MAX_BULK_LENGTH_RST;
            max_header_line_reg <= rmp_pkg::MAX_HEADER_LINE_RST;
        end
        else if (cfg_valid) begin
            case (cfg_index)
                rmp_pkg::REG_MAX_ARG_COUNT:   max_arg_count_reg   <= cfg_data[20:0];
                rmp_pkg::REG_MAX_BULK_LENGTH: max_bulk_length_reg <= cfg_data;
                rmp_pkg::REG_MAX_HEADER_LINE: max_header_line_reg <= cfg_data[16:0];
                default:                      max_arg_count_reg   <= max_arg_count_reg;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_valid  = byte_valid_reg;
    assign out_byte    = out_byte_reg;
    assign arg_index   = arg_index_reg;
    assign arg_end     = arg_end_reg;
    assign command_end = command_end_reg;
    assign error_code  = error_code_reg;

endmodule

`default_nettype wire

// File: test/resp_multibulk_request_parser_top_tb.sv
// Self-checking testbench for resp_multibulk_request_parser_top: directed and random RESP traffic.
// Depends on rmp_pkg and the parser RTL; predicts every output beat with its own parser model.
`timescale 1ns / 1ps

module resp_multibulk_request_parser_top_tb;

    // Index with no register behind it; a write to it must change nothing.
    localparam logic [1:0] REG_SPARE = 2'd3;

    // One output beat as the monitor sees it.
    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic [19:0] arg_index;
        logic        arg_end;
        logic        command_end;
        logic [2:0]  error_code;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic [19:0] arg_index;
    logic        arg_end;
    logic        command_end;
    logic [2:0]  error_code;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [29:0] cfg_data = 30'd0;

    resp_multibulk_request_parser_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_valid  (byte_valid),
        .out_byte    (out_byte),
        .arg_index   (arg_index),
        .arg_end     (arg_end),
        .command_end (command_end),
        .error_code  (error_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Request bytes waiting to be offered, and output beats the parser model predicts.
    logic [7:0] byte_queue[$];
    beat_t      parse_expect[$];

    int    mismatch_count = 0;
    beat_t predicted;
    beat_t seen_beat;
    beat_t want_beat;

    // Traffic shaping. calm switches off all random idling on both channels; hold_armed asks
    // the receiver for one long stall, which it counts out itself.
    bit calm = 1'b0;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // ------------------------------------------------------------------
    // Parser model: limits as last written, and the parse state.
    // ------------------------------------------------------------------
    logic [20:0] lim_args = rmp_pkg::MAX_ARG_COUNT_RST;
    logic [29:0] lim_bulk = rmp_pkg::MAX_BULK_LENGTH_RST;
    logic [16:0] lim_line = rmp_pkg::MAX_HEADER_LINE_RST;

    rmp_pkg::phase_t ps_phase = rmp_pkg::PH_IDLE;
    logic            ps_neg = 1'b0;
    logic [33:0]     ps_digits = '0;
    logic [16:0]     ps_line = '0;
    logic [20:0]     ps_args_left = '0;
    logic [29:0]     ps_bytes_left = '0;
    logic [19:0]     ps_arg = '0;
    rmp_pkg::err_t   ps_error = rmp_pkg::ERR_NONE;

    function automatic beat_t make_beat(input logic bv, input logic [7:0] data,
                                        input logic aend, input logic cend,
                                        input logic [2:0] code);
        beat_t r;
        r.byte_valid  = bv;
        r.out_byte    = data;
        r.arg_index   = ps_arg;
        r.arg_end     = aend;
        r.command_end = cend;
        r.error_code  = code;
        return r;
    endfunction

    // A fault latches its code, reports it once, and silences the parser for good.
    function automatic bit raise_fault(input rmp_pkg::err_t code, output beat_t r);
        ps_error = code;
        ps_phase = rmp_pkg::PH_ERR;
        r = make_beat(1'b0, 8'h00, 1'b0, 1'b0, code);
        return 1'b1;
    endfunction

    // Counts one header byte; true when the line has grown past the limit.
    function automatic bit header_overflow();
        logic [17:0] n;
        n = ps_line + 18'd1;
        if (n > lim_line)
            return 1'b1;
        ps_line = n[16:0];
        return 1'b0;
    endfunction

    // Decimal field of a header line. The three phases from base are: nothing seen yet
    // (possibly a minus sign), good digits, and a malformed number waiting for CR.
    function automatic rmp_pkg::phase_t digit_step(input rmp_pkg::phase_t base,
                                                   input logic [7:0] b);
        logic [3:0]  rel;
        logic [33:0] d;
        rel = ps_phase - base;
        if (rel == 4'd2)
            return rmp_pkg::phase_t'(base + 4'd2);
        if (b >= rmp_pkg::CHAR_ZERO && b <= rmp_pkg::CHAR_NINE) begin
            d = b - rmp_pkg::CHAR_ZERO;
            if (rel == 4'd0) begin
                // "-0" is not a legal spelling.
                if (d == 0 && ps_neg)
                    return rmp_pkg::phase_t'(base + 4'd2);
                ps_digits = d;
                return rmp_pkg::phase_t'(base + 4'd1);
            end
            // A leading zero followed by more digits is malformed.
            if (ps_digits == 0)
                return rmp_pkg::phase_t'(base + 4'd2);
            if (ps_digits > (rmp_pkg::DIGIT_MAX - d) / 10)
                ps_digits = rmp_pkg::DIGIT_MAX;
            else
                ps_digits = ps_digits * 10 + d;
            return rmp_pkg::phase_t'(base + 4'd1);
        end
        if (b == rmp_pkg::CHAR_MINUS && rel == 4'd0 && !ps_neg) begin
            ps_neg = 1'b1;
            return base;
        end
        return rmp_pkg::phase_t'(base + 4'd2);
    endfunction

    function automatic bit close_arg(input logic bv, input logic [7:0] data, output beat_t r);
        ps_args_left = ps_args_left - 21'd1;
        r = make_beat(bv, data, 1'b1, ps_args_left == 0, ps_error);
        ps_phase = rmp_pkg::PH_SKIP1;
        return 1'b1;
    endfunction

    // Advances the model by one request byte; returns 1 when that byte yields an output beat.
    function automatic bit parse_byte(input logic [7:0] b, output beat_t r);
        r = '0;
        case (ps_phase)
            rmp_pkg::PH_IDLE: begin
                if (b != rmp_pkg::CHAR_STAR)
                    return raise_fault(rmp_pkg::ERR_INLINE, r);
                ps_line = '0;
                if (header_overflow())
                    return raise_fault(rmp_pkg::ERR_LINE_LONG, r);
                ps_neg = 1'b0;
                ps_digits = '0;
                ps_phase = rmp_pkg::PH_CSTART;
            end
            rmp_pkg::PH_CSTART, rmp_pkg::PH_CDIG, rmp_pkg::PH_CBAD: begin
                if (b == rmp_pkg::CHAR_CR) begin
                    if (ps_phase != rmp_pkg::PH_CDIG)
                        return raise_fault(rmp_pkg::ERR_BAD_COUNT, r);
                    // Zero or negative counts are empty commands.
                    if (ps_neg || ps_digits == 0)
                        ps_args_left = '0;
                    else if (ps_digits > lim_args)
                        return raise_fault(rmp_pkg::ERR_BAD_COUNT, r);
                    else
                        ps_args_left = ps_digits[20:0];
                    ps_phase = rmp_pkg::PH_CLF;
                end
                else begin
                    if (header_overflow())
                        return raise_fault(rmp_pkg::ERR_LINE_LONG, r);
                    ps_phase = digit_step(rmp_pkg::PH_CSTART, b);
                end
            end
            rmp_pkg::PH_CLF: begin
                ps_arg = '0;
                ps_phase = (ps_args_left != 0) ? rmp_pkg::PH_DOLLAR : rmp_pkg::PH_IDLE;
            end
            rmp_pkg::PH_DOLLAR: begin
                if (b == rmp_pkg::CHAR_CR)
                    return raise_fault(rmp_pkg::ERR_NO_DOLLAR, r);
                ps_line = '0;
                if (header_overflow())
                    return raise_fault(rmp_pkg::ERR_LINE_LONG, r);
                ps_neg = 1'b0;
                ps_digits = '0;
                ps_phase = (b == rmp_pkg::CHAR_DOLLAR) ? rmp_pkg::PH_BSTART : rmp_pkg::PH_DBAD;
            end
            rmp_pkg::PH_DBAD: begin
                if (b == rmp_pkg::CHAR_CR)
                    return raise_fault(rmp_pkg::ERR_NO_DOLLAR, r);
                if (header_overflow())
                    return raise_fault(rmp_pkg::ERR_LINE_LONG, r);
            end
            rmp_pkg::PH_BSTART, rmp_pkg::PH_BDIG, rmp_pkg::PH_BBAD: begin
                if (b == rmp_pkg::CHAR_CR) begin
                    if (ps_phase != rmp_pkg::PH_BDIG || ps_neg
                        || ps_digits > lim_bulk)
                        return raise_fault(rmp_pkg::ERR_BAD_BULK, r);
                    ps_bytes_left = ps_digits[29:0];
                    ps_phase = rmp_pkg::PH_BLF;
                end
                else begin
                    if (header_overflow())
                        return raise_fault(rmp_pkg::ERR_LINE_LONG, r);
                    ps_phase = digit_step(rmp_pkg::PH_BSTART, b);
                end
            end
            rmp_pkg::PH_BLF: begin
                // An empty argument closes on the byte after the length line's CR.
                if (ps_bytes_left == 0)
                    return close_arg(1'b0, 8'h00, r);
                ps_phase = rmp_pkg::PH_DATA;
            end
            rmp_pkg::PH_DATA: begin
                ps_bytes_left = ps_bytes_left - 30'd1;
                if (ps_bytes_left == 0)
                    return close_arg(1'b1, b, r);
                r = make_beat(1'b1, b, 1'b0, 1'b0, ps_error);
                return 1'b1;
            end
            rmp_pkg::PH_SKIP1: begin
                ps_phase = rmp_pkg::PH_SKIP2;
            end
            rmp_pkg::PH_SKIP2: begin
                if (ps_args_left == 0) begin
                    ps_arg = '0;
                    ps_phase = rmp_pkg::PH_IDLE;
                end
                else begin
                    ps_arg = ps_arg + 20'd1;
                    ps_phase = rmp_pkg::PH_DOLLAR;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and the time limit.
    // ------------------------------------------------------------------
    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("resp_multibulk_request_parser_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver. On every accepted beat the model is stepped and any predicted
    // output beat is queued. A new beat is loaded only once the current one has gone,
    // and about one cycle in five is left empty unless the run is in its calm stretch.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                if (parse_byte(in_byte, predicted))
                    parse_expect.push_back(predicted);
            end
            if (!in_valid || in_ready) begin
                if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_queue.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It stalls at random, and once asked it holds out_ready low for a long
    // count so that the output register fills and the parser pushes back on the input.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_armed && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    function automatic string beat_text(input beat_t b);
        return $sformatf("bv=%0b byte=%02h idx=%0d aend=%0b cend=%0b err=%0d",
                         b.byte_valid, b.out_byte, b.arg_index, b.arg_end,
                         b.command_end, b.error_code);
    endfunction

    task automatic report_mismatch(input string what, input beat_t want, input beat_t seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected %s, got %s", $time, what, beat_text(want),
                     beat_text(seen));
    endtask

    // Monitor: every accepted output beat is matched against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            seen_beat.byte_valid  = byte_valid;
            seen_beat.out_byte    = out_byte;
            seen_beat.arg_index   = arg_index;
            seen_beat.arg_end     = arg_end;
            seen_beat.command_end = command_end;
            seen_beat.error_code  = error_code;
            if (parse_expect.size() == 0) begin
                report_mismatch("beat with nothing expected", '0, seen_beat);
            end
            else begin
                want_beat = parse_expect.pop_front();
                if (seen_beat !== want_beat)
                    report_mismatch("beat mismatch", want_beat, seen_beat);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Each builds request bytes in byte_queue.
    // ------------------------------------------------------------------
    task automatic push_noise(input int count);
        repeat (count) byte_queue.push_back(8'($urandom_range(255)));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_queue.push_back(s[i]);
    endtask

    // A header line: '*' or '$', the decimal value, CR, then the unchecked byte after it.
    task automatic push_number_line(input logic [7:0] lead, input longint value);
        byte_queue.push_back(lead);
        push_text($sformatf("%0d", value));
        byte_queue.push_back(rmp_pkg::CHAR_CR);
        push_noise(1);
    endtask

    // One argument: length line, payload, and the two unchecked trailing bytes.
    task automatic push_bulk(input int len);
        push_number_line(rmp_pkg::CHAR_DOLLAR, len);
        push_noise(len);
        push_noise(2);
    endtask

    // A well-formed command; about one argument in eight uses the longest length allowed.
    task automatic push_command(input int nargs, input int max_len);
        push_number_line(rmp_pkg::CHAR_STAR, nargs);
        repeat (nargs)
            push_bulk(($urandom_range(7) == 0) ? max_len : $urandom_range(max_len, 0));
    endtask

    task automatic push_random_command(input int max_args, input int max_len);
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            push_number_line(rmp_pkg::CHAR_STAR, 0);
        else if (pick < 6)
            push_number_line(rmp_pkg::CHAR_STAR, -longint'($urandom_range(99999, 1)));
        else if (pick < 7)
            push_number_line(rmp_pkg::CHAR_STAR, -64'sd99999999999);
        else
            push_command($urandom_range(max_args, 1), max_len);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [29:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            rmp_pkg::REG_MAX_ARG_COUNT:   lim_args = value[20:0];
            rmp_pkg::REG_MAX_BULK_LENGTH: lim_bulk = value[29:0];
            rmp_pkg::REG_MAX_HEADER_LINE: lim_line = value[16:0];
            default: ;
        endcase
    endtask

    // Waits until every queued byte has gone in and every predicted beat has come out,
    // then lets the clock run on so the parser has also finished bytes that yield nothing.
    task automatic wait_drained();
        do @(posedge clk);
        while (byte_queue.size() != 0 || in_valid || parse_expect.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // The error is sticky and reset comes only once, so the run ends with a single
    // protocol fault of a random kind, followed by noise that must yield nothing.
    task automatic push_fault(input rmp_pkg::err_t fault);
        logic [7:0] b;
        string      s;
        case (fault)
            rmp_pkg::ERR_INLINE: begin
                push_command(1, 1);
                b = 8'($urandom_range(255));
                if (b == rmp_pkg::CHAR_STAR)
                    b = 8'h00;
                byte_queue.push_back(b);
            end
            rmp_pkg::ERR_BAD_COUNT: begin
                case ($urandom_range(4))
                    0:       s = "*01";
                    1:       s = "*-0";
                    2:       s = "*";
                    3:       s = "*-";
                    default: s = $sformatf("*%0d", lim_args + 21'd1);
                endcase
                push_text(s);
                byte_queue.push_back(rmp_pkg::CHAR_CR);
            end
            rmp_pkg::ERR_NO_DOLLAR: begin
                push_number_line(rmp_pkg::CHAR_STAR, 2);
                push_bulk($urandom_range(1, 0));
                if ($urandom_range(1) == 0) begin
                    b = 8'($urandom_range(255));
                    if (b == rmp_pkg::CHAR_DOLLAR || b == rmp_pkg::CHAR_CR)
                        b = 8'h41;
                    byte_queue.push_back(b);
                    push_text("12");
                end
                byte_queue.push_back(rmp_pkg::CHAR_CR);
            end
            rmp_pkg::ERR_BAD_BULK: begin
                push_number_line(rmp_pkg::CHAR_STAR, 2);
                push_bulk(1);
                case ($urandom_range(5))
                    0:       s = "$-1";
                    1:       s = "$00";
                    2:       s = "$";
                    3:       s = "$99999999999";
                    4:       s = "$1x";
                    default: s = $sformatf("$%0d", lim_bulk + 30'd1);
                endcase
                push_text(s);
                byte_queue.push_back(rmp_pkg::CHAR_CR);
            end
            default: begin
                // One-byte header limit: the count digit already overflows the line.
                write_reg(rmp_pkg::REG_MAX_HEADER_LINE, 30'd1);
                push_text("*1");
                byte_queue.push_back(rmp_pkg::CHAR_CR);
            end
        endcase
        push_noise(24);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        int gen_args;
        int gen_len;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset limits: extreme payload bytes, an empty argument, empty commands
        // of zero, negative and saturating negative count.
        push_number_line(rmp_pkg::CHAR_STAR, 1);
        push_number_line(rmp_pkg::CHAR_DOLLAR, 3);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h5A);
        push_noise(2);
        push_number_line(rmp_pkg::CHAR_STAR, 2);
        push_bulk(0);
        push_bulk(1);
        push_number_line(rmp_pkg::CHAR_STAR, 0);
        push_number_line(rmp_pkg::CHAR_STAR, -7);
        push_number_line(rmp_pkg::CHAR_STAR, -64'sd99999999999);
        wait_drained();

        // Single-argument commands only, header line limit met exactly by a long
        // negative count.
        write_reg(rmp_pkg::REG_MAX_ARG_COUNT, 30'd1);
        write_reg(rmp_pkg::REG_MAX_BULK_LENGTH, 30'd536870911);
        write_reg(rmp_pkg::REG_MAX_HEADER_LINE, 30'd12);
        repeat (8) push_command(1, 12);
        push_number_line(rmp_pkg::CHAR_STAR, 0);
        push_number_line(rmp_pkg::CHAR_STAR, -64'sd1234567890);
        wait_drained();

        // No payload allowed at all, and a three-byte header limit.
        write_reg(rmp_pkg::REG_MAX_ARG_COUNT, 30'd5);
        write_reg(rmp_pkg::REG_MAX_BULK_LENGTH, 30'd0);
        write_reg(rmp_pkg::REG_MAX_HEADER_LINE, 30'd3);
        write_reg(REG_SPARE, 30'($urandom));
        push_number_line(rmp_pkg::CHAR_STAR, -9);
        repeat (10) push_command($urandom_range(5, 1), 0);
        push_command(5, 0);
        wait_drained();

        // Random well-formed traffic in three settings. The first uses the largest limits
        // and carries the long receiver stall; the second runs with no idling at all.
        for (int sub = 0; sub < 3; sub++) begin
            if (sub == 0) begin
                write_reg(rmp_pkg::REG_MAX_ARG_COUNT, 30'd1048576);
                write_reg(rmp_pkg::REG_MAX_BULK_LENGTH, 30'd536870912);
                write_reg(rmp_pkg::REG_MAX_HEADER_LINE, 30'd65536);
                gen_args = 6;
                gen_len  = 24;
            end
            else begin
                write_reg(rmp_pkg::REG_MAX_ARG_COUNT, 30'($urandom_range(6, 2)));
                write_reg(rmp_pkg::REG_MAX_BULK_LENGTH, 30'($urandom_range(24, 1)));
                write_reg(rmp_pkg::REG_MAX_HEADER_LINE, 30'($urandom_range(40, 14)));
                gen_args = lim_args;
                gen_len  = lim_bulk;
            end
            if (sub == 1)
                calm <= 1'b1;
            while (byte_queue.size() < 150)
                push_random_command(gen_args, gen_len);
            if (sub == 0)
                hold_armed <= 1'b1;
            wait_drained();
            calm <= 1'b0;
        end

        push_fault(rmp_pkg::err_t'($urandom_range(5, 1)));
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && parse_expect.size() == 0)
            $display("resp_multibulk_request_parser_top test passed");
        else
            $display("resp_multibulk_request_parser_top test failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/rmp_pkg.sv
hw/rtl/rmp_step.sv
hw/rtl/resp_multibulk_request_parser_top.sv
test/resp_multibulk_request_parser_top_tb.sv
